@@ hdl/jll_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jll_pkg
// Shared types and constants of the JSON line lexer.
// ----------------------------------------------------------------------------
package jll_pkg;

  localparam int unsigned MAX_LINE = 65535;
  // columns stop counting here
  localparam logic [15:0] COL_LIMIT = 16'((MAX_LINE < 65535) ? MAX_LINE : 65535);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_STR   = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_AFTER = 3'd3,
    MODE_NUM   = 3'd4,
    MODE_WORD  = 3'd5
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_PROP = 3'd0,
    KIND_STR  = 3'd1,
    KIND_ERR  = 3'd2,
    KIND_NUM  = 3'd3,
    KIND_KEY  = 3'd4,
    KIND_OP   = 3'd5
  } kind_t;

  typedef struct packed {
    lex_mode_t   lex_mode;
    logic [15:0] column;
    logic [15:0] token_start;
    logic [15:0] pending_start;
    logic [15:0] pending_stop;
    logic [5:0]  word_match;   // candidate keyword in [5:4], matched length in [3:0]
  } jll_state_t;

  typedef struct packed {
    logic [15:0] span_start;
    logic [15:0] span_stop;
    kind_t       token_kind;
    logic        run_last;
  } jll_span_t;

endpackage
`default_nettype wire

@@ hdl/jll_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jll_in_if / jll_out_if
// Valid/ready channels carrying one input byte or one token span per word.
// ----------------------------------------------------------------------------
interface jll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface jll_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] span_start;
  logic [15:0] span_stop;
  logic [2:0]  token_kind;
  logic        run_last;

  modport source (output valid, output span_start, output span_stop, output token_kind,
                  output run_last, input ready);
  modport sink   (input valid, input span_start, input span_stop, input token_kind,
                  input run_last, output ready);
endinterface
`default_nettype wire

@@ hdl/jll_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jll_step
// Lexer step: from the state and one byte, the next state and up to two spans.
// ----------------------------------------------------------------------------
module jll_step (
  input  jll_pkg::jll_state_t st,
  input  logic [7:0]          char_code,
  input  logic                line_end,
  output jll_pkg::jll_state_t st_nxt,
  output jll_pkg::jll_span_t  span0,
  output jll_pkg::jll_span_t  span1,
  output logic [1:0]          span_cnt
);

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd12 || c == 8'd11;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_numchar(input logic [7:0] c);
    return is_digit(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-";
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] cand);
    logic [3:0] len;
    case (cand)
      2'd1:    len = 4'd4;
      2'd2:    len = 4'd5;
      2'd3:    len = 4'd4;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // character idx of the candidate keyword
  function automatic logic [7:0] kw_at(input logic [1:0] cand, input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'd0;
    case (cand)
      2'd1: begin
        case (idx)
          4'd0:    ch = "t";
          4'd1:    ch = "r";
          4'd2:    ch = "u";
          4'd3:    ch = "e";
          default: ch = 8'd0;
        endcase
      end
      2'd2: begin
        case (idx)
          4'd0:    ch = "f";
          4'd1:    ch = "a";
          4'd2:    ch = "l";
          4'd3:    ch = "s";
          4'd4:    ch = "e";
          default: ch = 8'd0;
        endcase
      end
      2'd3: begin
        case (idx)
          4'd0:    ch = "n";
          4'd1:    ch = "u";
          4'd2:    ch = "l";
          4'd3:    ch = "l";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [5:0] word_begin(input logic [7:0] c);
    logic [5:0] wm;
    case (c)
      "t":     wm = {2'd1, 4'd1};
      "f":     wm = {2'd2, 4'd1};
      "n":     wm = {2'd3, 4'd1};
      default: wm = 6'd0;
    endcase
    return wm;
  endfunction

  function automatic logic [5:0] word_next(input logic [5:0] wm, input logic [7:0] c);
    logic [1:0] cand;
    logic [3:0] len;
    cand = wm[5:4];
    len  = wm[3:0];
    if (cand != 2'd0 && len < kw_len(cand) && kw_at(cand, len) == c) begin
      return {cand, len + 4'd1};
    end
    return 6'd0;
  endfunction

  function automatic jll_pkg::kind_t word_kind(input logic [5:0] wm);
    if (wm[5:4] != 2'd0 && wm[3:0] == kw_len(wm[5:4])) begin
      return jll_pkg::KIND_KEY;
    end
    return jll_pkg::KIND_ERR;
  endfunction

  logic [15:0]        pos;
  logic [15:0]        stop;

  // outcome of treating the byte as the start of something new
  logic               idle_emit;
  jll_pkg::kind_t     idle_kind;
  jll_pkg::lex_mode_t idle_mode;
  logic               idle_tok;
  logic [5:0]         idle_wm;

  logic               idle_run;
  logic               prior_emit;
  jll_pkg::jll_span_t prior;
  jll_pkg::jll_span_t idle_span;
  logic [5:0]         wm_adv;
  logic               is_op;

  assign pos  = (st.column > jll_pkg::COL_LIMIT) ? jll_pkg::COL_LIMIT : st.column;
  assign stop = (pos < jll_pkg::COL_LIMIT) ? pos + 16'd1 : jll_pkg::COL_LIMIT;
  assign wm_adv = word_next(st.word_match, char_code);
  assign is_op = char_code == "{" || char_code == "}" || char_code == "[" ||
                 char_code == "]" || char_code == ":" || char_code == ",";

  always_comb begin
    idle_emit = 1'b0;
    idle_kind = jll_pkg::KIND_ERR;
    idle_mode = jll_pkg::MODE_IDLE;
    idle_tok  = 1'b0;
    idle_wm   = word_begin(char_code);
    if (is_blank(char_code)) begin
      idle_emit = 1'b0;
    end else if (char_code == "\"") begin
      idle_tok  = 1'b1;
      idle_emit = line_end;
      idle_kind = jll_pkg::KIND_ERR;
      idle_mode = line_end ? jll_pkg::MODE_IDLE : jll_pkg::MODE_STR;
    end else if (is_digit(char_code) || char_code == "-") begin
      idle_tok  = 1'b1;
      idle_emit = line_end;
      idle_kind = jll_pkg::KIND_NUM;
      idle_mode = line_end ? jll_pkg::MODE_IDLE : jll_pkg::MODE_NUM;
    end else if (is_alpha(char_code)) begin
      idle_tok  = 1'b1;
      idle_emit = line_end;
      idle_kind = word_kind(idle_wm);
      idle_mode = line_end ? jll_pkg::MODE_IDLE : jll_pkg::MODE_WORD;
    end else begin
      idle_emit = 1'b1;
      idle_kind = is_op ? jll_pkg::KIND_OP : jll_pkg::KIND_ERR;
    end
  end

  always_comb begin
    st_nxt     = st;
    idle_run   = 1'b0;
    prior_emit = 1'b0;
    prior      = '{span_start: st.token_start, span_stop: stop,
                   token_kind: jll_pkg::KIND_ERR, run_last: 1'b0};

    case (st.lex_mode)
      jll_pkg::MODE_STR: begin
        if (char_code == "\\") begin
          prior_emit = line_end;
          st_nxt.lex_mode = jll_pkg::MODE_ESC;
        end else if (char_code == "\"") begin
          prior_emit = line_end;
          prior.token_kind = jll_pkg::KIND_STR;
          st_nxt.pending_start = st.token_start;
          st_nxt.pending_stop  = stop;
          st_nxt.lex_mode = jll_pkg::MODE_AFTER;
        end else begin
          prior_emit = line_end;
        end
      end
      jll_pkg::MODE_ESC: begin
        prior_emit = line_end;
        st_nxt.lex_mode = jll_pkg::MODE_STR;
      end
      jll_pkg::MODE_AFTER: begin
        prior.span_start = st.pending_start;
        prior.span_stop  = st.pending_stop;
        prior.token_kind = jll_pkg::KIND_STR;
        if (is_blank(char_code)) begin
          prior_emit = line_end;
        end else begin
          prior_emit = 1'b1;
          if (char_code == ":") begin
            prior.token_kind = jll_pkg::KIND_PROP;
          end
          idle_run = 1'b1;
        end
      end
      jll_pkg::MODE_NUM: begin
        prior.token_kind = jll_pkg::KIND_NUM;
        if (is_numchar(char_code)) begin
          prior_emit = line_end;
        end else begin
          prior_emit = 1'b1;
          prior.span_stop = pos;
          idle_run = 1'b1;
        end
      end
      jll_pkg::MODE_WORD: begin
        if (is_alpha(char_code)) begin
          st_nxt.word_match = wm_adv;
          prior_emit = line_end;
          prior.token_kind = word_kind(wm_adv);
        end else begin
          prior_emit = 1'b1;
          prior.span_stop = pos;
          prior.token_kind = word_kind(st.word_match);
          idle_run = 1'b1;
        end
      end
      default: begin
        idle_run = 1'b1;
      end
    endcase

    if (idle_run) begin
      st_nxt.lex_mode = idle_mode;
      if (idle_tok) begin
        st_nxt.token_start = pos;
      end
      if (is_alpha(char_code)) begin
        st_nxt.word_match = idle_wm;
      end
    end

    if (line_end) begin
      st_nxt = '{lex_mode: jll_pkg::MODE_IDLE, default: '0};
    end else begin
      st_nxt.column = stop;
    end
  end

  always_comb begin
    idle_span = '{span_start: pos, span_stop: stop, token_kind: idle_kind, run_last: 1'b1};
    span1 = idle_span;
    if (prior_emit) begin
      span0 = prior;
      span_cnt = (idle_run && idle_emit) ? 2'd2 : 2'd1;
    end else begin
      span0 = idle_span;
      span_cnt = (idle_run && idle_emit) ? 2'd1 : 2'd0;
    end
    span0.run_last = (span_cnt == 2'd1);
  end

endmodule
`default_nettype wire

@@ hdl/json_line_lexer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// json_line_lexer
// Lexer for one line of JSON text that emits token spans for highlighting.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on in_word while the output queue has room and
// returns spans (start column, stop column, kind) on out_word; run_last
// marks the last span a byte caused. A byte passes an input register, the
// lexer step logic and a two-word output queue; it waits in the input
// register until its spans fit, and they are then registered into the queue.
// Most bytes cause zero or one span and the block then sustains one byte per
// clock while the receiver is ready. A byte that closes a token and is itself
// a one-byte token causes two spans and fills the queue; with the queue
// draining one word per cycle it stays full under one-span bytes and drops
// by one at each byte that causes no span, and the input stalls when another
// two-span byte arrives while the queue is full. All lexer state clears after
// the byte flagged line_end. No startup pass: bytes are taken right after reset.
// ----------------------------------------------------------------------------
module json_line_lexer (
  input  wire         clk,
  input  wire         rst_n,
  jll_in_if.sink      in_word,
  jll_out_if.source   out_word
);

  logic               s1_valid_r;
  logic [7:0]         s1_char_r;
  logic               s1_end_r;

  jll_pkg::jll_state_t st_r;
  jll_pkg::jll_state_t st_nxt;

  jll_pkg::jll_span_t span0;
  jll_pkg::jll_span_t span1;
  logic [1:0]         span_cnt;

  jll_pkg::jll_span_t q0_r, q0_nxt;
  jll_pkg::jll_span_t q1_r, q1_nxt;
  logic [1:0]         qcnt_r, qcnt_nxt;

  jll_pkg::jll_span_t rem0;
  logic [1:0]         rem_cnt;
  logic               pop;
  logic               fire;
  logic               in_take;

  jll_step u_step (
    .st        (st_r),
    .char_code (s1_char_r),
    .line_end  (s1_end_r),
    .st_nxt    (st_nxt),
    .span0     (span0),
    .span1     (span1),
    .span_cnt  (span_cnt)
  );

  assign out_word.valid      = qcnt_r != 2'd0;
  assign out_word.span_start = q0_r.span_start;
  assign out_word.span_stop  = q0_r.span_stop;
  assign out_word.token_kind = q0_r.token_kind;
  assign out_word.run_last   = q0_r.run_last;

  assign pop = out_word.valid && out_word.ready;

  always_comb begin
    if (pop) begin
      rem0    = q1_r;
      rem_cnt = qcnt_r - 2'd1;
    end else begin
      rem0    = q0_r;
      rem_cnt = qcnt_r;
    end
    // the byte's spans must fit in what is left of the queue
    fire = s1_valid_r && (({1'b0, rem_cnt} + {1'b0, span_cnt}) <= 3'd2);
    q0_nxt = (rem_cnt != 2'd0) ? rem0 : span0;
    if (rem_cnt == 2'd2) begin
      q1_nxt = q1_r;
    end else if (rem_cnt == 2'd1) begin
      q1_nxt = span0;
    end else begin
      q1_nxt = span1;
    end
    qcnt_nxt = rem_cnt + (fire ? span_cnt : 2'd0);
  end

  assign in_word.ready = !s1_valid_r || fire;
  assign in_take       = in_word.valid && in_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      qcnt_r     <= 2'd0;
      st_r       <= '{lex_mode: jll_pkg::MODE_IDLE, default: '0};
    end else begin
      qcnt_r <= qcnt_nxt;
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    if (in_take) begin
      s1_char_r <= in_word.char_code;
      s1_end_r  <= in_word.line_end;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/jll_span_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jll_span_checker
// Watches the byte and span channels of the JSON line lexer, predicts the
// spans each accepted byte must produce and compares them in order.
// ----------------------------------------------------------------------------
module jll_span_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire [7:0]  in_char_code,
  input  wire        in_line_end,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire [15:0] out_span_start,
  input  wire [15:0] out_span_stop,
  input  wire [2:0]  out_token_kind,
  input  wire        out_run_last,
  output int         fail_count,
  output int         pending_spans
);

  localparam int PRINT_CAP = 30;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  jll_pkg::lex_mode_t mode;
  logic [15:0]        col;
  logic [15:0]        tok_start;
  logic [15:0]        pend_start;
  logic [15:0]        pend_stop;
  logic [5:0]         wmatch;       // candidate keyword in [5:4], matched length in [3:0]
  jll_pkg::jll_span_t expected_spans[$];
  int                 spans_this_byte;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd12 || c == 8'd11;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_numchar(input logic [7:0] c);
    return is_digit(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-";
  endfunction

  function automatic logic [3:0] keyword_len(input logic [1:0] cand);
    return (cand == 2'd2) ? 4'd5 : 4'd4;
  endfunction

  function automatic logic [7:0] keyword_char(input logic [1:0] cand, input logic [3:0] idx);
    string word;
    case (cand)
      2'd1:    word = "true";
      2'd2:    word = "false";
      default: word = "null";
    endcase
    return word[idx];
  endfunction

  function automatic jll_pkg::kind_t word_kind(input logic [5:0] wm);
    return (wm[5:4] != 2'd0 && wm[3:0] == keyword_len(wm[5:4])) ?
           jll_pkg::KIND_KEY : jll_pkg::KIND_ERR;
  endfunction

  task automatic clear_state();
    mode       = jll_pkg::MODE_IDLE;
    col        = '0;
    tok_start  = '0;
    pend_start = '0;
    pend_stop  = '0;
    wmatch     = '0;
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_span(input logic [15:0] s, input logic [15:0] e, input jll_pkg::kind_t k);
    jll_pkg::jll_span_t sp;
    sp.span_start = s;
    sp.span_stop  = e;
    sp.token_kind = k;
    sp.run_last   = 1'b0;
    expected_spans.insert(expected_spans.size(), sp);
    spans_this_byte++;
  endtask

  task automatic word_step(input logic [7:0] c);
    logic [1:0] cand;
    logic [3:0] len;
    cand = wmatch[5:4];
    len  = wmatch[3:0];
    if (cand != 2'd0 && len < keyword_len(cand) && keyword_char(cand, len) == c)
      wmatch = {cand, len + 4'd1};
    else
      wmatch = '0;
  endtask

  // byte seen with no token open
  task automatic lex_idle(input logic [7:0] c, input logic [15:0] pos, input logic [15:0] stop,
                          input logic eol);
    mode = jll_pkg::MODE_IDLE;
    if (!is_blank(c)) begin
      if (c == CH_QUOTE) begin
        tok_start = pos;
        if (eol) push_span(pos, stop, jll_pkg::KIND_ERR);
        else mode = jll_pkg::MODE_STR;
      end else if (is_digit(c) || c == "-") begin
        tok_start = pos;
        if (eol) push_span(pos, stop, jll_pkg::KIND_NUM);
        else mode = jll_pkg::MODE_NUM;
      end else if (is_alpha(c)) begin
        tok_start = pos;
        case (c)
          "t":     wmatch = {2'd1, 4'd1};
          "f":     wmatch = {2'd2, 4'd1};
          "n":     wmatch = {2'd3, 4'd1};
          default: wmatch = '0;
        endcase
        if (eol) push_span(pos, stop, word_kind(wmatch));
        else mode = jll_pkg::MODE_WORD;
      end else if (c == "{" || c == "}" || c == "[" || c == "]" || c == ":" || c == ",") begin
        push_span(pos, stop, jll_pkg::KIND_OP);
      end else begin
        push_span(pos, stop, jll_pkg::KIND_ERR);
      end
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic eol);
    logic [15:0]        pos;
    logic [15:0]        stop;
    jll_pkg::jll_span_t tail;
    pos  = (col > jll_pkg::COL_LIMIT) ? jll_pkg::COL_LIMIT : col;
    stop = (pos < jll_pkg::COL_LIMIT) ? pos + 16'd1 : jll_pkg::COL_LIMIT;
    spans_this_byte = 0;
    case (mode)
      jll_pkg::MODE_STR: begin
        if (c == CH_BSLASH) begin
          if (eol) push_span(tok_start, stop, jll_pkg::KIND_ERR);
          else mode = jll_pkg::MODE_ESC;
        end else if (c == CH_QUOTE) begin
          if (eol) begin
            push_span(tok_start, stop, jll_pkg::KIND_STR);
          end else begin
            pend_start = tok_start;
            pend_stop  = stop;
            mode       = jll_pkg::MODE_AFTER;
          end
        end else if (eol) begin
          push_span(tok_start, stop, jll_pkg::KIND_ERR);
        end
      end
      jll_pkg::MODE_ESC: begin
        if (eol) push_span(tok_start, stop, jll_pkg::KIND_ERR);
        else mode = jll_pkg::MODE_STR;
      end
      jll_pkg::MODE_AFTER: begin
        if (is_blank(c)) begin
          if (eol) push_span(pend_start, pend_stop, jll_pkg::KIND_STR);
        end else begin
          push_span(pend_start, pend_stop,
                    (c == CH_COLON) ? jll_pkg::KIND_PROP : jll_pkg::KIND_STR);
          lex_idle(c, pos, stop, eol);
        end
      end
      jll_pkg::MODE_NUM: begin
        if (is_numchar(c)) begin
          if (eol) push_span(tok_start, stop, jll_pkg::KIND_NUM);
        end else begin
          push_span(tok_start, pos, jll_pkg::KIND_NUM);
          lex_idle(c, pos, stop, eol);
        end
      end
      jll_pkg::MODE_WORD: begin
        if (is_alpha(c)) begin
          word_step(c);
          if (eol) push_span(tok_start, stop, word_kind(wmatch));
        end else begin
          push_span(tok_start, pos, word_kind(wmatch));
          lex_idle(c, pos, stop, eol);
        end
      end
      default: lex_idle(c, pos, stop, eol);
    endcase
    if (spans_this_byte > 0) begin
      tail = expected_spans[expected_spans.size() - 1];
      tail.run_last = 1'b1;
      expected_spans[expected_spans.size() - 1] = tail;
    end
    if (eol) clear_state();
    else col = stop;
  endtask

  task automatic check_span();
    jll_pkg::jll_span_t want;
    if (expected_spans.size() == 0) begin
      report_mismatch($sformatf("unexpected span %0d..%0d kind %0d last %0d",
                                out_span_start, out_span_stop, out_token_kind, out_run_last));
      return;
    end
    want = expected_spans.pop_front();
    if (out_span_start !== want.span_start || out_span_stop !== want.span_stop ||
        out_token_kind !== want.token_kind || out_run_last !== want.run_last)
      report_mismatch($sformatf("span %0d..%0d kind %0d last %0d, want %0d..%0d kind %0d last %0d",
                                out_span_start, out_span_stop, out_token_kind, out_run_last,
                                want.span_start, want.span_stop, want.token_kind,
                                want.run_last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_spans.delete();
      fail_count = 0;
    end else begin
      // predict first: a byte's spans never leave in the cycle it is taken
      if (in_valid && in_ready) lex_byte(in_char_code, in_line_end);
      if (out_valid && out_ready) check_span();
    end
    pending_spans <= expected_spans.size();
  end

endmodule

@@ tb/sv/json_line_lexer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_line_lexer_test
// Drives lines of JSON-like text into the lexer with bursty input and a
// stalling receiver; the span checker beside the block grades every span.
// ----------------------------------------------------------------------------
module json_line_lexer_test;

  localparam int RANDOM_ITEMS  = 1920;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int SETTLE_CYCLES = 16;
  localparam string BLANKS     = " \t\n\r\013\014";
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_style_t;

  logic       clk = 1'b0;
  logic       rst_n;
  int         fail_count;
  int         pending_spans;
  int         burst_left = 0;
  int         sent_random = 0;
  int         cycle_count = 0;
  logic [7:0] line_buf[$];
  rx_style_t  rx_style = RX_OPEN;
  int         rx_left = 0;
  int         rx_tick = 0;

  jll_in_if  in_ch ();
  jll_out_if out_ch ();

  json_line_lexer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  jll_span_checker span_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_char_code   (in_ch.char_code),
    .in_line_end    (in_ch.line_end),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_span_start (out_ch.span_start),
    .out_span_stop  (out_ch.span_stop),
    .out_token_kind (out_ch.token_kind),
    .out_run_last   (out_ch.run_last),
    .fail_count     (fail_count),
    .pending_spans  (pending_spans)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // append one byte to the line being built
  task automatic line_add(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endtask

  // called at a rising edge, returns at the edge that takes the word
  task automatic send_byte(input logic [7:0] c, input logic eol);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.line_end  <= eol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) line_add(s[i]);
  endtask

  task automatic add_string(input logic as_prop);
    logic [7:0] c;
    line_add(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 7))
        0: begin
          line_add(CH_BSLASH);
          line_add(pick_char("\"\\nt/u0"));
        end
        1: begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_QUOTE || c == CH_BSLASH) c = "q";
          line_add(c);
        end
        default: line_add(pick_char("abcXYZ019 :,{}[]-."));
      endcase
    end
    line_add(CH_QUOTE);
    if (as_prop) begin
      repeat ($urandom_range(0, 2)) line_add(pick_char(BLANKS));
      line_add(":");
    end
  endtask

  task automatic add_word();
    string w;
    w = "";
    case ($urandom_range(0, 10))
      0: w = "true";
      1: w = "false";
      2: w = "null";
      3: w = "tru";
      4: w = "nul";
      5: w = "fals";
      6: w = "truex";
      7: w = "nulll";
      8: w = "True";
      default: repeat ($urandom_range(1, 6)) line_add(pick_char("abtfnuelrsxzQ"));
    endcase
    load_text(w);
  endtask

  task automatic build_random_line();
    int r;
    int keep;
    line_buf.delete();
    repeat ($urandom_range(1, 10)) begin
      r = $urandom_range(0, 99);
      if (r < 20) add_string(1'b0);
      else if (r < 35) add_string(1'b1);
      else if (r < 50) begin
        line_add(pick_char("-0123456789"));
        repeat ($urandom_range(0, 6)) line_add(pick_char("0123456789.eE+-"));
      end else if (r < 65) add_word();
      else if (r < 85) line_add(pick_char("{}[]:,"));
      else if (r < 92) line_add(8'($urandom_range(0, 255)));
      else repeat ($urandom_range(1, 3)) line_add(pick_char(BLANKS));
      // no blank between tokens gives the two-span cases
      if ($urandom_range(0, 1) == 0) line_add(pick_char(BLANKS));
    end
    // cut some lines mid-token
    if ($urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, line_buf.size());
      while (line_buf.size() > keep) void'(line_buf.pop_back());
    end
  endtask

  // receiver: ready pattern changes style whenever rx_left runs out
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        rx_left  = $urandom_range(20, 300);
      end
      rx_left--;
      rx_tick++;
      case (rx_style)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_LIGHT:    out_ch.ready <= ($urandom_range(0, 9) >= 3);
        RX_PERIODIC: out_ch.ready <= (rx_tick % 4 != 0);
        default:     out_ch.ready <= ($urandom_range(0, 9) >= 7);
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= 8'd0;
    in_ch.line_end  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // property with escape and blank before colon, number and word closed by operators
    line_buf.delete();
    load_text("{\"a\\\"\" :[-1.5e+2,true]}");
    send_line();
    // closed string cut by line end after a blank
    line_buf.delete();
    load_text("\"x\"\t");
    send_line();
    // open string ending in a backslash
    line_buf.delete();
    load_text("\"\\");
    send_line();
    // bad word closed by a one-byte error
    line_buf.delete();
    load_text("nul");
    line_add(8'hFF);
    send_line();
    line_buf.delete();
    line_add(8'h00);
    send_line();

    while (sent_random < RANDOM_ITEMS) begin
      build_random_line();
      send_line();
      sent_random += line_buf.size();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending_spans != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
